// ===== rtl/assert_macros.svh =====
// Assertion macros used by the frame receiver control module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
// The module that uses it must have signals named clk and rst_n.
`define LFRT_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("lfrt assertion failed");

// Property whose consequent must hold in the cycle after its antecedent.
// The module that uses it must have signals named clk and rst_n.
`define LFRT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lfrt assertion failed");

`endif

// ===== rtl/lfrt_pkg.sv =====
// Package with types and constants of the length framed receiver.
`timescale 1ns / 1ps
`default_nettype none

package lfrt_pkg;

    // Default geometry of the frame store and the length byte position.
    localparam int unsigned STORE_DEPTH_DEF = 64;
    localparam int unsigned LENGTH_POS_DEF  = 2;

    // Frame length is the length byte plus this many header and trailer bytes.
    localparam int unsigned LEN_OFFSET = 4;

    // Timeout register reset value and the saturation limit of the idle timer.
    localparam logic [15:0] TIMEOUT_RESET = 16'd256;
    localparam logic [15:0] IDLE_MAX      = 16'hFFFF;

    // Operation codes of an input transaction.
    typedef enum logic [1:0] {
        OP_BYTE    = 2'd0,
        OP_TICK    = 2'd1,
        OP_RELEASE = 2'd2,
        OP_READ    = 2'd3
    } op_t;

    // Event codes reported with every result.
    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_COMPLETE = 2'd1,
        EV_TIMEOUT  = 2'd2,
        EV_OVERFLOW = 2'd3
    } evt_t;

    // Receiver state.
    typedef enum logic {
        ST_RECEIVING = 1'b0,
        ST_HOLDING   = 1'b1
    } state_t;

    // Status of one processed transaction, handed to the output register.
    typedef struct packed {
        logic       store_we;
        evt_t       evt;
        logic       holding;
        logic [6:0] frame_len;
    } rx_status_t;

endpackage

`default_nettype wire

// ===== rtl/lfrt_ctrl.sv =====
// Frame assembly control: byte counter, length check, idle timer and timeout register.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module lfrt_ctrl
    import lfrt_pkg::*;
#(
    parameter int unsigned StoreDepth = STORE_DEPTH_DEF,
    parameter int unsigned LengthPos  = LENGTH_POS_DEF,
    localparam int unsigned CntW      = $clog2(StoreDepth + 1)
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_wr_en,
    input  wire logic [15:0]     cfg_wr_data,
    input  wire logic            accept,
    input  wire logic [1:0]      operation,
    input  wire logic [7:0]      rx_byte,
    output      logic [CntW-1:0] byte_count,
    output      rx_status_t      status
);

    // Width wide enough for the frame length compare (length byte plus offset).
    localparam int unsigned CmpW = (CntW > 9) ? CntW + 1 : 10;
    localparam int unsigned LenW = (CntW > 7) ? CntW : 7;

    state_t          state_reg, state_next;
    logic [CntW-1:0] byte_count_reg, byte_count_next;
    logic [CntW-1:0] held_length_reg, held_length_next;
    logic            timer_running_reg, timer_running_next;
    logic [15:0]     idle_ticks_reg, idle_ticks_next;
    logic [7:0]      length_byte_reg, length_byte_next;
    logic [15:0]     timeout_reg;

    logic [CntW-1:0] count_inc;
    logic [7:0]      length_val;
    logic [CmpW-1:0] frame_total;
    logic [15:0]     idle_inc;
    logic [LenW-1:0] held_ext;
    evt_t            evt;
    logic            store_we;
    op_t             op;

    assign op = op_t'(operation);

    // Timeout configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_wr_en)
        begin
            timeout_reg <= cfg_wr_data;
        end
    end

    // Control state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_RECEIVING;
            byte_count_reg    <= '0;
            held_length_reg   <= '0;
            timer_running_reg <= 1'b0;
            idle_ticks_reg    <= '0;
            length_byte_reg   <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            byte_count_reg    <= byte_count_next;
            held_length_reg   <= held_length_next;
            timer_running_reg <= timer_running_next;
            idle_ticks_reg    <= idle_ticks_next;
            length_byte_reg   <= length_byte_next;
        end
    end

    // Arithmetic shared by the next-state logic.
    assign count_inc   = byte_count_reg + CntW'(1);
    assign length_val  = (byte_count_reg == CntW'(LengthPos)) ? rx_byte : length_byte_reg;
    assign frame_total = CmpW'(length_val) + CmpW'(LEN_OFFSET);
    assign idle_inc    = (idle_ticks_reg == IDLE_MAX) ? idle_ticks_reg
                                                      : idle_ticks_reg + 16'd1;

    // Next state and event for the accepted transaction.
    always_comb
    begin
        state_next         = state_reg;
        byte_count_next    = byte_count_reg;
        held_length_next   = held_length_reg;
        timer_running_next = timer_running_reg;
        idle_ticks_next    = idle_ticks_reg;
        length_byte_next   = length_byte_reg;
        evt                = EV_NONE;
        store_we           = 1'b0;

        if (accept)
        begin
            case (op)
                OP_BYTE:
                begin
                    if (state_reg == ST_RECEIVING)
                    begin
                        if (byte_count_reg >= CntW'(StoreDepth))
                        begin
                            // Store full: drop the frame and the byte.
                            timer_running_next = 1'b0;
                            idle_ticks_next    = '0;
                            byte_count_next    = '0;
                            held_length_next   = '0;
                            evt                = EV_OVERFLOW;
                        end
                        else
                        begin
                            store_we         = 1'b1;
                            byte_count_next  = count_inc;
                            idle_ticks_next  = '0;
                            length_byte_next = length_val;
                            if (byte_count_reg == '0)
                            begin
                                timer_running_next = 1'b1;
                            end
                            else if ((count_inc > CntW'(LengthPos)) &&
                                     (CmpW'(count_inc) >= frame_total))
                            begin
                                // Frame complete: hold it until released.
                                timer_running_next = 1'b0;
                                held_length_next   = count_inc;
                                state_next         = ST_HOLDING;
                                byte_count_next    = '0;
                                evt                = EV_COMPLETE;
                            end
                        end
                    end
                end
                OP_TICK:
                begin
                    if (timer_running_reg)
                    begin
                        idle_ticks_next = idle_inc;
                        if (idle_inc >= timeout_reg)
                        begin
                            timer_running_next = 1'b0;
                            idle_ticks_next    = '0;
                            byte_count_next    = '0;
                            held_length_next   = '0;
                            state_next         = ST_RECEIVING;
                            evt                = EV_TIMEOUT;
                        end
                    end
                end
                OP_RELEASE:
                begin
                    timer_running_next = 1'b0;
                    idle_ticks_next    = '0;
                    byte_count_next    = '0;
                    held_length_next   = '0;
                    state_next         = ST_RECEIVING;
                end
                default:
                begin
                    // A read leaves the control state alone.
                end
            endcase
        end
    end

    // Status for the output register.
    assign held_ext         = LenW'(held_length_next);
    assign status.store_we  = store_we;
    assign status.evt       = evt;
    assign status.holding   = (state_next == ST_HOLDING);
    assign status.frame_len = (state_next == ST_HOLDING) ? held_ext[6:0] : 7'd0;
    assign byte_count       = byte_count_reg;

    // While a frame is held, the timer is stopped and no partial frame exists.
    `LFRT_ASSERT_ALWAYS(a_hold_idle, (state_reg != ST_HOLDING) ||
                        (!timer_running_reg && byte_count_reg == '0))

    // The idle counter only counts while the timer runs.
    `LFRT_ASSERT_ALWAYS(a_idle_clear, timer_running_reg || idle_ticks_reg == '0)

    // The byte count never passes the store depth.
    `LFRT_ASSERT_ALWAYS(a_count_range, byte_count_reg <= CntW'(StoreDepth))

    // A timeout leaves the receiver empty with the timer stopped.
    `LFRT_ASSERT_NEXT(a_timeout_drop, evt == EV_TIMEOUT,
                      !timer_running_reg && byte_count_reg == '0 &&
                      state_reg == ST_RECEIVING)

endmodule

`default_nettype wire

// ===== rtl/length_framed_receiver_with_timeout.sv =====
// Top level of the length framed receiver with inter-byte timeout.
//
//  Channel   Direction  Handshake            Contents
//  input     in         in_valid / in_stall  operation, rx_byte, read_index
//  result    out        out_valid/out_stall  frame_ready, frame_length, read_data, event_res
//  config    in         cfg_wr_en            cfg_wr_data (timeout in ticks)
//
// Each transaction's result is in the output register at the next clock edge,
// and a new transaction is taken every cycle while in_stall is low.
// The rate is set by the combinational counter and length compare in the
// control logic and the one-port frame store, written or read once a cycle.
// in_stall rises only while a result waits in the output register and
// out_stall is high. Reset clears all control state; the frame store is not
// cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module length_framed_receiver_with_timeout
    import lfrt_pkg::*;
#(
    parameter int unsigned StoreDepth = STORE_DEPTH_DEF,
    parameter int unsigned LengthPos  = LENGTH_POS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        in_valid,
    output      logic        in_stall,
    input  wire logic [1:0]  operation,
    input  wire logic [7:0]  rx_byte,
    input  wire logic [5:0]  read_index,
    output      logic        out_valid,
    input  wire logic        out_stall,
    output      logic        frame_ready,
    output      logic [6:0]  frame_length,
    output      logic [7:0]  read_data,
    output      logic [1:0]  event_res
);

    localparam int unsigned AddrW = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
    localparam int unsigned CntW  = $clog2(StoreDepth + 1);
    localparam int unsigned IdxW  = (AddrW > 6) ? AddrW + 1 : 7;

    logic            accept;
    logic [CntW-1:0] byte_count;
    rx_status_t      status;
    logic [IdxW-1:0] idx_ext;
    logic [AddrW-1:0] rd_addr;
    logic [AddrW-1:0] wr_addr;
    logic            idx_ok;

    logic            out_valid_reg, out_valid_next;
    logic            frame_ready_reg;
    logic [6:0]      frame_length_reg;
    logic [7:0]      read_data_reg;
    logic [1:0]      event_res_reg;

    logic [7:0]      frame_store [StoreDepth];

    // A transaction is taken unless a result is waiting on a stalled output.
    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;

    // Frame assembly control.
    lfrt_ctrl #(
        .StoreDepth (StoreDepth),
        .LengthPos  (LengthPos)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .operation   (operation),
        .rx_byte     (rx_byte),
        .byte_count  (byte_count),
        .status      (status)
    );

    // Store addressing.
    assign idx_ext = IdxW'(read_index);
    assign idx_ok  = idx_ext < IdxW'(StoreDepth);
    assign rd_addr = idx_ext[AddrW-1:0];
    assign wr_addr = byte_count[AddrW-1:0];

    // Frame store write port.
    always_ff @(posedge clk)
    begin
        if (status.store_we)
        begin
            frame_store[wr_addr] <= rx_byte;
        end
    end

    // Output payload register, with the store read data registered here.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            frame_ready_reg  <= status.holding;
            frame_length_reg <= status.frame_len;
            event_res_reg    <= status.evt;
            if ((op_t'(operation) == OP_READ) && idx_ok)
            begin
                read_data_reg <= frame_store[rd_addr];
            end
            else
            begin
                read_data_reg <= 8'd0;
            end
        end
    end

    // Output valid: set on a new transaction, kept while the result is stalled.
    always_comb
    begin
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign frame_ready  = frame_ready_reg;
    assign frame_length = frame_length_reg;
    assign read_data    = read_data_reg;
    assign event_res    = event_res_reg;

endmodule

`default_nettype wire

// ===== dv/length_framed_receiver_with_timeout_tb.sv =====
// Self-checking testbench for the length framed receiver with inter-byte timeout.
`timescale 1ns / 1ps

module length_framed_receiver_with_timeout_tb;
    import lfrt_pkg::*;

    localparam int STORE_DEPTH  = STORE_DEPTH_DEF;
    localparam int LENGTH_POS   = LENGTH_POS_DEF;
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int REPORT_MAX   = 10;

    // One input transaction and the status the block reports for it.
    typedef struct {
        op_t        op;
        logic [7:0] rx_byte;
        logic [5:0] read_index;
    } rx_item_t;

    typedef struct {
        logic       ready;
        logic [6:0] length;
        logic [7:0] data;
        evt_t       ev;
    } frame_status_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic [1:0]  operation   = '0;
    logic [7:0]  rx_byte     = '0;
    logic [5:0]  read_index  = '0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic        frame_ready;
    logic [6:0]  frame_length;
    logic [7:0]  read_data;
    logic [1:0]  event_res;

    // Shadow of the receiver state, kept in step with accepted transactions.
    logic [7:0]  store_copy [STORE_DEPTH];
    bit          written_copy [STORE_DEPTH];
    bit          holding       = 1'b0;
    int          byte_count    = 0;
    int          held_length   = 0;
    bit          timer_on      = 1'b0;
    logic [15:0] idle_ticks    = '0;
    logic [15:0] timeout_ticks = TIMEOUT_RESET;

    rx_item_t      pending_items[$];
    frame_status_t expected_status[$];

    int          produced   = 0;
    int          mismatches = 0;
    int          cycles     = 0;
    bit          item_taken = 1'b0;
    int          burst_left = 0;
    int          gap_left   = 0;
    logic [15:0] stall_pat  = '0;
    int          stall_pos  = 0;

    length_framed_receiver_with_timeout DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .rx_byte      (rx_byte),
        .read_index   (read_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .frame_ready  (frame_ready),
        .frame_length (frame_length),
        .read_data    (read_data),
        .event_res    (event_res)
    );

    // Clock with a 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Abandon the partial frame and stop the inter-byte timer.
    function automatic void drop_partial();
        timer_on    = 1'b0;
        idle_ticks  = '0;
        byte_count  = 0;
        held_length = 0;
    endfunction

    // Apply one transaction to the shadow state and return the status it produces.
    function automatic frame_status_t frame_rx_step(rx_item_t it);
        frame_status_t res;
        res.data = '0;
        res.ev   = EV_NONE;
        case (it.op)
            OP_BYTE:
            begin
                // Bytes are ignored while a complete frame is held.
                if (!holding)
                begin
                    if (byte_count >= STORE_DEPTH)
                    begin
                        drop_partial();
                        res.ev = EV_OVERFLOW;
                    end
                    else
                    begin
                        store_copy[byte_count]   = it.rx_byte;
                        written_copy[byte_count] = 1'b1;
                        byte_count++;
                        idle_ticks = '0;
                        if (byte_count == 1)
                            timer_on = 1'b1;
                        else if (byte_count > LENGTH_POS &&
                                 byte_count >= int'(store_copy[LENGTH_POS]) + LEN_OFFSET)
                        begin
                            timer_on    = 1'b0;
                            held_length = byte_count;
                            holding     = 1'b1;
                            byte_count  = 0;
                            res.ev      = EV_COMPLETE;
                        end
                    end
                end
            end
            OP_TICK:
            begin
                if (timer_on)
                begin
                    if (idle_ticks < IDLE_MAX)
                        idle_ticks++;
                    if (idle_ticks >= timeout_ticks)
                    begin
                        drop_partial();
                        holding = 1'b0;
                        res.ev  = EV_TIMEOUT;
                    end
                end
            end
            OP_RELEASE:
            begin
                holding = 1'b0;
                drop_partial();
            end
            default:
            begin
                res.data = store_copy[it.read_index];
            end
        endcase
        res.ready  = holding;
        res.length = holding ? 7'(held_length) : 7'd0;
        return res;
    endfunction

    // Stimulus helpers that append transactions to the pending queue.
    function automatic void push_item(op_t op, logic [7:0] b, logic [5:0] idx);
        rx_item_t it;
        it.op         = op;
        it.rx_byte    = b;
        it.read_index = idx;
        pending_items.push_back(it);
        produced++;
    endfunction

    function automatic void push_byte(logic [7:0] b);
        push_item(OP_BYTE, b, 6'($urandom));
    endfunction

    function automatic void push_op(op_t op);
        push_item(op, 8'($urandom), 6'($urandom));
    endfunction

    function automatic void push_read(logic [5:0] idx);
        push_item(OP_READ, 8'($urandom), idx);
    endfunction

    // Only entries already written may be read; the written set only grows.
    function automatic void push_read_written();
        int idx_list[$];
        for (int i = 0; i < STORE_DEPTH; i++)
            if (written_copy[i])
                idx_list.push_back(i);
        if (idx_list.size() == 0)
            push_op(OP_TICK);
        else
            push_read(6'(idx_list[$urandom_range(0, idx_list.size() - 1)]));
    endfunction

    // Frame bytes with the length byte in place and a few ticks that stay short of the timeout.
    function automatic void queue_frame(int len_byte, int nbytes);
        int max_ticks;
        max_ticks = (timeout_ticks > 4) ? 3 : int'(timeout_ticks) - 1;
        for (int i = 0; i < nbytes; i++)
        begin
            if (i == LENGTH_POS)
                push_byte(8'(len_byte));
            else
                push_byte(8'($urandom));
            if (i + 1 < nbytes && max_ticks >= 1 && $urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, max_ticks)) push_op(OP_TICK);
        end
    endfunction

    // Mostly well-formed frames with random content, plus broken frames and noise.
    function automatic void run_random(int count);
        int start;
        int sel;
        int len_byte;
        start = produced;
        while (produced - start < count)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 45)
            begin
                push_op(OP_RELEASE);
                len_byte = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60)
                                                       : $urandom_range(0, 12);
                queue_frame(len_byte, len_byte + LEN_OFFSET);
                repeat ($urandom_range(0, 4))
                begin
                    case ($urandom_range(0, 2))
                        0:       push_read_written();
                        1:       push_byte(8'($urandom));
                        default: push_op(OP_TICK);
                    endcase
                end
                if ($urandom_range(0, 3) != 0)
                    push_op(OP_RELEASE);
            end
            else if (sel < 50)
            begin
                // Length byte too large for the store: fill it, then usually overflow.
                push_op(OP_RELEASE);
                queue_frame($urandom_range(61, 255), STORE_DEPTH);
                if ($urandom_range(0, 3) != 0)
                    push_byte(8'($urandom));
            end
            else if (sel < 65)
            begin
                // Partial frame left to time out, or dropped by a release.
                push_op(OP_RELEASE);
                len_byte = $urandom_range(0, 20);
                queue_frame(len_byte, $urandom_range(1, len_byte + LEN_OFFSET - 1));
                if (timeout_ticks <= 300)
                    repeat ((timeout_ticks == 0) ? 1 : int'(timeout_ticks)) push_op(OP_TICK);
                else
                    push_op(OP_RELEASE);
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:       push_byte(8'($urandom));
                    1:       push_op(OP_TICK);
                    2:       push_op(OP_RELEASE);
                    default: push_read_written();
                endcase
            end
        end
    endfunction

    // Wait until every queued transaction is accepted and every result checked.
    task automatic wait_idle();
        while (pending_items.size() != 0 || expected_status.size() != 0)
            @(negedge clk);
    endtask

    // Timeout register write, done only while the block is idle.
    task automatic write_timeout(input logic [15:0] value);
        wait_idle();
        @(negedge clk);
        cfg_wr_data <= value;
        cfg_wr_en   <= 1'b1;
        @(negedge clk);
        cfg_wr_en     <= 1'b0;
        timeout_ticks = value;
    endtask

    // Sender: drives the head of the pending queue in bursts separated by gaps.
    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && !item_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                in_valid   <= 1'b1;
                operation  <= pending_items[0].op;
                rx_byte    <= pending_items[0].rx_byte;
                read_index <= pending_items[0].read_index;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                             : $urandom_range(1, 30);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: stalls on a 16-bit pattern that is redrawn each time it runs out.
    always @(negedge clk)
    begin
        out_stall <= stall_pat[stall_pos];
        if (stall_pos == 15)
        begin
            stall_pos = 0;
            case ($urandom_range(0, 3))
                0:       stall_pat = '0;
                1:       stall_pat = 16'($urandom | $urandom);
                default: stall_pat = 16'($urandom & $urandom);
            endcase
        end
        else
            stall_pos++;
    end

    // Monitor: checks each result transaction, then records an accepted input transaction.
    always @(posedge clk)
    begin
        frame_status_t want;
        rx_item_t      it;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_status.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("unexpected result: ready=%0d len=%0d data=%02h ev=%0d",
                                 frame_ready, frame_length, read_data, event_res);
                end
                else
                begin
                    want = expected_status.pop_front();
                    if (frame_ready !== want.ready || frame_length !== want.length ||
                        read_data !== want.data || event_res !== want.ev)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("mismatch: expected ready=%0d len=%0d data=%02h ev=%0d, %s",
                                     want.ready, want.length, want.data, want.ev,
                                     $sformatf("got ready=%0d len=%0d data=%02h ev=%0d",
                                               frame_ready, frame_length, read_data,
                                               event_res));
                    end
                end
            end
            item_taken = in_valid && !in_stall;
            if (item_taken)
            begin
                it.op         = op_t'(operation);
                it.rx_byte    = rx_byte;
                it.read_index = read_index;
                expected_status.push_back(frame_rx_step(it));
                void'(pending_items.pop_front());
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Test sequence: directed cases, then random phases under several timeout settings.
    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Tick with the timer stopped and release with nothing received.
        push_op(OP_TICK);
        push_op(OP_RELEASE);
        // Shortest frame: length byte zero, four bytes in all.
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'hFF);
        // While held: byte ignored, tick has no effect, stored bytes readable.
        push_byte(8'hA5);
        push_op(OP_TICK);
        push_read(6'd0);
        push_read(6'd1);
        push_read(6'd3);
        push_op(OP_RELEASE);
        // Release in the middle of a frame discards it.
        push_byte(8'h11);
        push_byte(8'h22);
        push_op(OP_RELEASE);
        push_op(OP_TICK);

        // Timeout of one tick.
        write_timeout(16'd1);
        push_op(OP_RELEASE);
        push_byte(8'h80);
        push_op(OP_TICK);
        // Largest frame that fits, then a frame that overruns the store.
        push_op(OP_RELEASE);
        queue_frame(STORE_DEPTH - LEN_OFFSET, STORE_DEPTH);
        push_read(6'd63);
        push_read(6'd0);
        push_op(OP_RELEASE);
        queue_frame(255, STORE_DEPTH);
        push_byte(8'h5A);
        push_read(6'd63);
        run_random(250);

        // Timeout register zero: the first tick after a byte discards the frame.
        write_timeout(16'd0);
        push_op(OP_RELEASE);
        push_byte(8'h3C);
        push_op(OP_TICK);
        run_random(150);

        write_timeout(16'd3);
        run_random(300);

        // Largest timeout: a few ticks after a byte leave the partial frame in place.
        write_timeout(IDLE_MAX);
        push_op(OP_RELEASE);
        push_byte(8'hC3);
        repeat (5) push_op(OP_TICK);
        push_op(OP_RELEASE);
        run_random(100);

        write_timeout(16'd12);
        run_random(250);

        write_timeout(TIMEOUT_RESET);
        run_random(150);

        wait_idle();
        repeat (4) @(negedge clk);
        if (mismatches == 0 && expected_status.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
